// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define MAPD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Check a property on every rising clock edge, reset cycles included.
`define MAPD_ASSERT_ANY(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== rtl/core/mapd_pkg.sv =====
package mapd_pkg;

   localparam int DEFAULT_WINDOW_LENGTH = 20;
   localparam int DEFAULT_SAMPLE_BITS   = 12;

   localparam int PSI_GAIN_BITS      = 17;
   localparam int ZERO_PRESSURE_BITS = 17;
   localparam int DEPTH_GAIN_BITS    = 18;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 18;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PSI_GAIN      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ZERO_PRESSURE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEPTH_GAIN    = 2'd2;

   localparam logic [PSI_GAIN_BITS-1:0]      PSI_GAIN_RESET      = 17'd67602;
   localparam logic [ZERO_PRESSURE_BITS-1:0] ZERO_PRESSURE_RESET = 17'd3763;
   localparam logic [DEPTH_GAIN_BITS-1:0]    DEPTH_GAIN_RESET    = 18'd151127;

   // Q16 gains: drop this many fraction bits after each product.
   localparam int GAIN_FRAC_BITS = 16;

   localparam int PRESSURE_BITS  = 17;
   localparam int DEPTH_BITS     = 20;
   localparam int RSP_TDATA_BITS = ((PRESSURE_BITS + DEPTH_BITS + 7) / 8) * 8;

   localparam logic [PRESSURE_BITS-1:0] PRESSURE_MAX = '1;

   // Window control issued by the sequencer.
   typedef struct packed {
      logic rd;   // fetch the oldest entry and capture the new sample
      logic upd;  // update the running sum, store the sample, advance
   } window_ctl_type;

endpackage

// ===== rtl/core/mapd_window.sv =====
module mapd_window #(
   parameter int WINDOW_LENGTH = mapd_pkg::DEFAULT_WINDOW_LENGTH,
   parameter int SAMPLE_BITS   = mapd_pkg::DEFAULT_SAMPLE_BITS,
   parameter int SUM_BITS      = SAMPLE_BITS + $clog2(WINDOW_LENGTH)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mapd_pkg::window_ctl_type ctl,
   input  logic [SAMPLE_BITS-1:0]   sample,
   output logic [SUM_BITS-1:0]      sum
);

   localparam int IDX_BITS = $clog2(WINDOW_LENGTH);
   localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(WINDOW_LENGTH - 1);

   logic [SAMPLE_BITS-1:0]   window_ff [WINDOW_LENGTH];
   logic [WINDOW_LENGTH-1:0] valid_ff;
   logic [WINDOW_LENGTH-1:0] valid_in;
   logic [IDX_BITS-1:0]      idx_ff;
   logic [IDX_BITS-1:0]      idx_in;
   logic [SUM_BITS-1:0]      sum_ff;
   logic [SUM_BITS-1:0]      sum_in;
   logic [SAMPLE_BITS-1:0]   rd_data_ff;
   logic                     rd_valid_ff;
   logic [SAMPLE_BITS-1:0]   sample_ff;
   logic [SAMPLE_BITS-1:0]   oldest;

   // Entries never written since reset count as zero.
   assign oldest = rd_valid_ff ? rd_data_ff : '0;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      sum_in   = sum_ff;
      if (ctl.upd) begin
         valid_in[idx_ff] = 1'b1;
         idx_in = (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
         sum_in = sum_ff - SUM_BITS'(oldest) + SUM_BITS'(sample_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         idx_ff   <= '0;
         sum_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd) begin
         rd_data_ff  <= window_ff[idx_ff];
         rd_valid_ff <= valid_ff[idx_ff];
         sample_ff   <= sample;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.upd) begin
         window_ff[idx_ff] <= sample_ff;
      end
   end

   assign sum = sum_ff;

endmodule

// ===== rtl/core/mapd_mult.sv =====
module mapd_mult #(
   parameter int A_BITS = 19,
   parameter int B_BITS = 19
) (
   input  logic                            clock,
   input  logic                            en,
   input  logic signed [A_BITS-1:0]        a,
   input  logic signed [B_BITS-1:0]        b,
   output logic signed [A_BITS+B_BITS-1:0] prod
);

   logic signed [A_BITS+B_BITS-1:0] prod_ff;

   // Hold the product until the next issue.
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= (A_BITS+B_BITS)'(a) * (A_BITS+B_BITS)'(b);
      end
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/core/mapd_seq.sv =====
module mapd_seq #(
   parameter int SUM_BITS   = 17,
   parameter int MUL_A_BITS = 19,
   parameter int MUL_B_BITS = 19
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_fire,
   output logic                                       idle,
   output mapd_pkg::window_ctl_type                   win_ctl,
   input  logic [SUM_BITS-1:0]                        sum,
   output logic                                       mul_en,
   output logic signed [MUL_A_BITS-1:0]               mul_a,
   output logic signed [MUL_B_BITS-1:0]               mul_b,
   input  logic signed [MUL_A_BITS+MUL_B_BITS-1:0]    prod,
   input  logic [mapd_pkg::PSI_GAIN_BITS-1:0]         psi_gain,
   input  logic [mapd_pkg::ZERO_PRESSURE_BITS-1:0]    zero_pressure,
   input  logic [mapd_pkg::DEPTH_GAIN_BITS-1:0]       depth_gain,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   output logic [mapd_pkg::RSP_TDATA_BITS-1:0]        rsp_tdata
);

   localparam int P_BITS    = mapd_pkg::PRESSURE_BITS;
   localparam int D_BITS    = mapd_pkg::DEPTH_BITS;
   localparam int FRAC      = mapd_pkg::GAIN_FRAC_BITS;
   localparam int DIFF_BITS = P_BITS + 1;
   localparam int PROD_BITS = MUL_A_BITS + MUL_B_BITS;
   localparam int PAD_BITS  = mapd_pkg::RSP_TDATA_BITS - P_BITS - D_BITS;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SUM   = 3'd1;
   localparam logic [2:0] S_MUL_P = 3'd2;
   localparam logic [2:0] S_SCALE = 3'd3;
   localparam logic [2:0] S_MUL_D = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]           state_ff;
   logic [2:0]           state_in;
   logic [P_BITS-1:0]    press_ff;
   logic [P_BITS-1:0]    press_in;
   logic [DIFF_BITS-1:0] diff;
   logic                 rsp_tvalid_ff;
   logic                 rsp_tvalid_in;
   logic [P_BITS-1:0]    rsp_press_ff;
   logic [D_BITS-1:0]    rsp_depth_ff;
   logic                 rsp_load;
   logic                 out_free;

   assign diff     = {1'b0, press_ff} - {1'b0, zero_pressure};
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      press_in      = press_ff;
      win_ctl       = '0;
      mul_en        = 1'b0;
      mul_a         = {{(MUL_A_BITS-SUM_BITS){1'b0}}, sum};
      mul_b         = {{(MUL_B_BITS-mapd_pkg::PSI_GAIN_BITS){1'b0}}, psi_gain};
      rsp_load      = 1'b0;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               win_ctl.rd = 1'b1;
               state_in   = S_SUM;
            end
         end
         S_SUM: begin
            win_ctl.upd = 1'b1;
            state_in    = S_MUL_P;
         end
         S_MUL_P: begin
            mul_en   = 1'b1;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            // Saturate the Q16-scaled sum to the pressure range.
            if (prod[PROD_BITS-1:FRAC+P_BITS] != '0) begin
               press_in = mapd_pkg::PRESSURE_MAX;
            end else begin
               press_in = prod[FRAC +: P_BITS];
            end
            state_in = S_MUL_D;
         end
         S_MUL_D: begin
            mul_en   = 1'b1;
            mul_a    = {{(MUL_A_BITS-DIFF_BITS){diff[DIFF_BITS-1]}}, diff};
            mul_b    = {{(MUL_B_BITS-mapd_pkg::DEPTH_GAIN_BITS){1'b0}}, depth_gain};
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_tvalid_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      press_ff <= press_in;
      if (rsp_load) begin
         rsp_press_ff <= press_ff;
         // Arithmetic shift of the signed product, keep the low depth bits.
         rsp_depth_ff <= prod[FRAC +: D_BITS];
      end
   end

   assign idle       = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{PAD_BITS{1'b0}}, rsp_depth_ff, rsp_press_ff};

endmodule

// ===== rtl/core/moving_average_pressure_depth.sv =====
// Moving-average pressure and depth: each transfer on req_ carries one raw
// converter sample; the block keeps the last WINDOW_LENGTH samples (zeros
// after reset, so early results read low) with a running sum, and returns
// one transfer on rsp_ with pressure = min((sum * psi_gain) >> 16, 131071)
// in 1/256 psi and depth = ((pressure - zero_pressure) * depth_gain) >>> 16
// in 1/256 ft, two's complement. Each sample passes the window memory read,
// the sum update, the pressure product, the saturation step, the depth product
// and the output register load, both products on the one shared multiplier;
// req_tready comes back as the result lands in the output register, so no
// new sample is taken before the last is done. The last step holds while an
// earlier result still waits unaccepted in the output register, which
// stretches the sample time by that stall. A finished result waits in the
// output register while the next sample is taken. Write psi_gain,
// zero_pressure and depth_gain through csr_ only while no sample is in work.
module moving_average_pressure_depth #(
   parameter int WINDOW_LENGTH = mapd_pkg::DEFAULT_WINDOW_LENGTH,
   parameter int SAMPLE_BITS   = mapd_pkg::DEFAULT_SAMPLE_BITS,
   parameter int REQ_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Sample stream.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [REQ_TDATA_BITS-1:0]             req_tdata,   // sample
   // Result stream.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mapd_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,   // pressure, depth
   // Register writes.
   input  logic                                  csr_we,
   input  logic [mapd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mapd_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW_LENGTH);
   localparam int DIFF_BITS  = mapd_pkg::PRESSURE_BITS + 1;
   localparam int MUL_A_BITS = ((SUM_BITS > DIFF_BITS) ? SUM_BITS : DIFF_BITS) + 1;
   localparam int MUL_B_BITS = mapd_pkg::DEPTH_GAIN_BITS + 1;

   logic [mapd_pkg::PSI_GAIN_BITS-1:0]      psi_gain_ff;
   logic [mapd_pkg::ZERO_PRESSURE_BITS-1:0] zero_pressure_ff;
   logic [mapd_pkg::DEPTH_GAIN_BITS-1:0]    depth_gain_ff;

   mapd_pkg::window_ctl_type               win_ctl;
   logic [SUM_BITS-1:0]                    sum;
   logic                                   mul_en;
   logic signed [MUL_A_BITS-1:0]           mul_a;
   logic signed [MUL_B_BITS-1:0]           mul_b;
   logic signed [MUL_A_BITS+MUL_B_BITS-1:0] prod;
   logic                                   idle;
   logic                                   req_fire;

   assign req_tready = idle;
   assign req_fire   = req_tvalid && idle;

   // Configuration registers; drop writes to unknown indexes.
   always_ff @(posedge clock) begin
      if (reset) begin
         psi_gain_ff      <= mapd_pkg::PSI_GAIN_RESET;
         zero_pressure_ff <= mapd_pkg::ZERO_PRESSURE_RESET;
         depth_gain_ff    <= mapd_pkg::DEPTH_GAIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            mapd_pkg::CSR_PSI_GAIN: begin
               psi_gain_ff <= csr_wdata[mapd_pkg::PSI_GAIN_BITS-1:0];
            end
            mapd_pkg::CSR_ZERO_PRESSURE: begin
               zero_pressure_ff <= csr_wdata[mapd_pkg::ZERO_PRESSURE_BITS-1:0];
            end
            mapd_pkg::CSR_DEPTH_GAIN: begin
               depth_gain_ff <= csr_wdata[mapd_pkg::DEPTH_GAIN_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Circular sample window with running sum.
   mapd_window #(
      .WINDOW_LENGTH (WINDOW_LENGTH),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .SUM_BITS      (SUM_BITS)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .ctl    (win_ctl),
      .sample (req_tdata[SAMPLE_BITS-1:0]),
      .sum    (sum)
   );

   // One multiplier shared by the pressure and the depth scaling.
   mapd_mult #(
      .A_BITS (MUL_A_BITS),
      .B_BITS (MUL_B_BITS)
   ) u_mult (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   // Sequencer, scaling steps and output register.
   mapd_seq #(
      .SUM_BITS   (SUM_BITS),
      .MUL_A_BITS (MUL_A_BITS),
      .MUL_B_BITS (MUL_B_BITS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_fire      (req_fire),
      .idle          (idle),
      .win_ctl       (win_ctl),
      .sum           (sum),
      .mul_en        (mul_en),
      .mul_a         (mul_a),
      .mul_b         (mul_b),
      .prod          (prod),
      .psi_gain      (psi_gain_ff),
      .zero_pressure (zero_pressure_ff),
      .depth_gain    (depth_gain_ff),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata)
   );

endmodule

// ===== rtl/core/mapd_checker.sv =====
`include "assert_macros.svh"

module mapd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [mapd_pkg::RSP_TDATA_BITS-1:0] rsp_tdata
);

   localparam int USED_BITS = mapd_pkg::PRESSURE_BITS + mapd_pkg::DEPTH_BITS;

   `MAPD_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   `MAPD_ASSERT(a_busy_after_accept, clock, reset, req_tvalid && req_tready |=> !req_tready ##1 !req_tready ##1 !req_tready ##1 !req_tready ##1 !req_tready, "sample taken while busy")

   `MAPD_ASSERT(a_result_from_work, clock, reset, $rose(rsp_tvalid) |-> !$past(req_tready), "result without sample in work")

   `MAPD_ASSERT(a_pad_zero, clock, reset, rsp_tvalid |-> rsp_tdata[mapd_pkg::RSP_TDATA_BITS-1:USED_BITS] == '0, "result padding not zero")

   `MAPD_ASSERT_ANY(a_reset_state, clock, reset |=> !rsp_tvalid && req_tready, "reset left block busy")

endmodule

bind moving_average_pressure_depth mapd_checker u_mapd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import mapd_pkg::*;

   localparam int WIN_LEN     = DEFAULT_WINDOW_LENGTH;
   localparam int SAMPLE_W    = DEFAULT_SAMPLE_BITS;
   localparam int REQ_BITS    = ((SAMPLE_W + 7) / 8) * 8;
   localparam int HALF_PERIOD = 2;
   localparam int RESET_CYCLES = 7;
   // Longest run of cycles with no transfer on either channel before giving up.
   // Covers the receiver hold-off, idle bursts and the sample time.
   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASE_ITEMS = 250;
   localparam int REPORT_LIMIT = 10;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam logic [CSR_DATA_BITS-1:0]  CSR_ALL_ONES = '1;
   localparam logic [CSR_DATA_BITS-1:0]  ZERO_PRESSURE_SPAN = 18'd84480;

   typedef struct packed {
      logic [PRESSURE_BITS-1:0] pressure;
      logic [DEPTH_BITS-1:0]    depth;
   } reading_type;

   // DUT inputs, all driven to known values from time zero.
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_BITS-1:0]        req_tdata = '0;        // sample
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0]  rsp_tdata;             // pressure, depth
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0]   csr_wdata = '0;

   // Shadow of the block: register copies, sample window and running sum.
   logic [PSI_GAIN_BITS-1:0]      psi_gain_q;
   logic [ZERO_PRESSURE_BITS-1:0] zero_pressure_q;
   logic [DEPTH_GAIN_BITS-1:0]    depth_gain_q;
   logic [SAMPLE_W-1:0]           sample_window [WIN_LEN];
   int unsigned                   window_slot;
   logic [16:0]                   window_total;

   reading_type expected_readings [$];

   bit          idle_enable = 1'b1;
   bit          rsp_hold_request = 1'b0;
   int unsigned fault_count = 0;
   int unsigned quiet_cycles = 0;

   moving_average_pressure_depth u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Advance the shadow window by one sample and queue the reading it yields.
   function automatic void predict_reading(input logic [SAMPLE_W-1:0] value);
      logic [33:0]              scaled_sum;
      logic [17:0]              raw_pressure;
      logic [PRESSURE_BITS-1:0] pressure;
      longint                   gauge;
      longint                   depth_full;
      reading_type              reading;
      window_total = window_total - 17'(sample_window[window_slot]) + 17'(value);
      sample_window[window_slot] = value;
      window_slot = (window_slot == WIN_LEN - 1) ? 0 : window_slot + 1;
      scaled_sum = 34'(window_total) * 34'(psi_gain_q);
      raw_pressure = 18'(scaled_sum >> GAIN_FRAC_BITS);
      // Clamp the average at the top of the 17-bit pressure range.
      pressure = (raw_pressure > 18'(PRESSURE_MAX)) ? PRESSURE_MAX
                                                    : raw_pressure[PRESSURE_BITS-1:0];
      gauge = longint'(pressure) - longint'(zero_pressure_q);
      // Arithmetic shift rounds toward minus infinity for negative depths.
      depth_full = (gauge * longint'(depth_gain_q)) >>> GAIN_FRAC_BITS;
      reading.pressure = pressure;
      reading.depth    = depth_full[DEPTH_BITS-1:0];
      expected_readings.push_back(reading);
   endfunction

   // Write one register at a falling edge; mirror it into the shadow copy.
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_PSI_GAIN:      psi_gain_q      = value[PSI_GAIN_BITS-1:0];
         CSR_ZERO_PRESSURE: zero_pressure_q = value[ZERO_PRESSURE_BITS-1:0];
         CSR_DEPTH_GAIN:    depth_gain_q    = value[DEPTH_GAIN_BITS-1:0];
         default: ;  // unused index: block ignores it
      endcase
      @(negedge clock);
   endtask

   task automatic write_gains(input logic [CSR_DATA_BITS-1:0] psi,
                              input logic [CSR_DATA_BITS-1:0] bias,
                              input logic [CSR_DATA_BITS-1:0] depth);
      write_csr(CSR_PSI_GAIN, psi);
      write_csr(CSR_ZERO_PRESSURE, bias);
      write_csr(CSR_DEPTH_GAIN, depth);
   endtask

   // Offer one sample, with an occasional idle burst before it; hold tvalid
   // high on return so back-to-back samples never toggle it within a step.
   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      int unsigned gap;
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 9);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_BITS'(value);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_reading(value);
      @(negedge clock);
   endtask

   // Drop tvalid and wait until every queued reading has come back, so the
   // block is idle and registers may be written.
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (expected_readings.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample(input bit lean_high);
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return SAMPLE_MAX;
      if (lean_high) return SAMPLE_W'($urandom_range(3600, 4095));
      return SAMPLE_W'($urandom_range(0, 4095));
   endfunction

   task automatic send_random_samples(input int unsigned count, input bit lean_high);
      repeat (count) send_sample(pick_sample(lean_high));
   endtask

   // Right after reset: default gains, window still filling with zeros.
   task automatic test_window_fill();
      send_sample('0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(12'd1);
      send_sample(12'd2048);
      send_sample(12'd4094);
      settle_block();
   endtask

   // Full-scale samples with the largest gain push the average past 17 bits.
   task automatic test_pressure_saturation();
      write_gains(CSR_ALL_ONES, '0, CSR_ALL_ONES);
      repeat (WIN_LEN - 2) send_sample(SAMPLE_MAX);
      settle_block();
   endtask

   // Zero pressure against the largest bias gives the deepest negative depth.
   task automatic test_negative_depth();
      write_gains('0, CSR_ALL_ONES, CSR_ALL_ONES);
      send_sample(SAMPLE_MAX);
      settle_block();
   endtask

   // A write to the unused index must leave every register untouched.
   task automatic test_unused_index();
      write_gains(18'd65536, 18'd1000, 18'd65536);
      write_csr(CSR_UNUSED, CSR_ALL_ONES);
      send_sample(12'd37);
      settle_block();
   endtask

   task automatic test_random_mix();
      // Largest gain with samples leaning high: saturation under random data.
      write_gains(CSR_ALL_ONES, 18'd0, CSR_ALL_ONES);
      send_random_samples(PHASE_ITEMS, 1'b1);
      settle_block();
      // No gain, large bias: negative depths throughout.
      write_gains('0, ZERO_PRESSURE_SPAN, CSR_ALL_ONES);
      send_random_samples(PHASE_ITEMS, 1'b0);
      settle_block();
      // Random registers, upper write-data bits included.
      write_gains(CSR_DATA_BITS'($urandom), CSR_DATA_BITS'($urandom),
                  CSR_DATA_BITS'($urandom));
      send_random_samples(PHASE_ITEMS, 1'b0);
      settle_block();
      write_gains(PSI_GAIN_RESET, ZERO_PRESSURE_RESET, DEPTH_GAIN_RESET);
      send_random_samples(PHASE_ITEMS, 1'b1);
      settle_block();
   endtask

   // Receiver holds off for a long stretch while samples keep coming, so the
   // block backs up and drops req_tready.
   task automatic test_backpressure();
      write_gains(CSR_DATA_BITS'($urandom_range(40000, 131071)),
                  CSR_DATA_BITS'($urandom_range(0, 84480)),
                  CSR_DATA_BITS'($urandom));
      rsp_hold_request = 1'b1;
      send_random_samples(PHASE_ITEMS, 1'b0);
      settle_block();
   endtask

   // Last part: no idling on either side, tightest spacing the block allows.
   task automatic test_full_rate();
      idle_enable = 1'b0;
      write_gains(CSR_DATA_BITS'($urandom), CSR_DATA_BITS'($urandom),
                  CSR_DATA_BITS'($urandom));
      send_random_samples(PHASE_ITEMS, 1'b0);
      settle_block();
   endtask

   // Receiver: mostly ready, random stall bursts, and one long hold-off on
   // request, counted here cycle by cycle.
   initial begin
      int unsigned held;
      int unsigned gap;
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            rsp_tready <= 1'b0;
            held = 0;
            while (held < HOLD_CYCLES) begin
               @(negedge clock);
               held++;
            end
            rsp_hold_request = 1'b0;
         end else if (idle_enable && !reset && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Compare every result transfer with the oldest queued reading.
   always @(posedge clock) begin
      reading_type want;
      logic [PRESSURE_BITS-1:0] got_pressure;
      logic [DEPTH_BITS-1:0]    got_depth;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_pressure = rsp_tdata[PRESSURE_BITS-1:0];
         got_depth    = rsp_tdata[PRESSURE_BITS +: DEPTH_BITS];
         if (expected_readings.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $display("unexpected result: pressure %0d depth %0d",
                        got_pressure, $signed(got_depth));
         end else begin
            want = expected_readings.pop_front();
            if (got_pressure !== want.pressure || got_depth !== want.depth) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("mismatch: pressure exp %0d got %0d, depth exp %0d got %0d",
                           want.pressure, got_pressure,
                           $signed(want.depth), $signed(got_depth));
            end
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      psi_gain_q      = PSI_GAIN_RESET;
      zero_pressure_q = ZERO_PRESSURE_RESET;
      depth_gain_q    = DEPTH_GAIN_RESET;
      foreach (sample_window[i]) sample_window[i] = '0;
      window_slot  = 0;
      window_total = '0;

      // Hold reset, then release it at a falling edge.
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_window_fill();
      test_pressure_saturation();
      test_negative_depth();
      test_unused_index();
      test_random_mix();
      test_backpressure();
      test_full_rate();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && expected_readings.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/mapd_pkg.sv
rtl/core/mapd_window.sv
rtl/core/mapd_mult.sv
rtl/core/mapd_seq.sv
rtl/core/moving_average_pressure_depth.sv
rtl/core/mapd_checker.sv
tb/tb_top.sv
